// ===== rtl/core/nvt_pkg.sv =====
// Shared types, sizes and name helpers for the name vote tally table.
`default_nettype none

package nvt_pkg;

	localparam int DEPTH       = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int MAX_EMIT    = 32;
	localparam int NAME_BYTES  = 19;
	localparam int NAME_W      = NAME_BYTES * 8;
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int USED_W      = $clog2(DEPTH + 1);
	localparam int EMIT_LIMIT  = (DEPTH < MAX_EMIT) ? DEPTH : MAX_EMIT;

	typedef struct packed {
		logic [NAME_W-1:0]      name;
		logic [COUNT_WIDTH-1:0] count;
	} entry_t;

	typedef enum logic [1:0] {
		OP_PASS,
		OP_INC,
		OP_NEW
	} cell_op_t;

	// Control handed from the sequencer to the cell row.
	typedef struct packed {
		logic     shift;
		cell_op_t op;
	} chain_ctl_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		return (en && c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
	endfunction

	// A name ends at its first zero byte; everything after it reads as zero.
	function automatic logic [NAME_W-1:0] canon(input logic [NAME_W-1:0] raw);
		logic              ended;
		logic [7:0]        c;
		logic [NAME_W-1:0] r;
		ended = 1'b0;
		r     = '0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			c = raw[i*8 +: 8];
			if (ended) begin
				c = 8'h00;
			end else if (c == 8'h00) begin
				ended = 1'b1;
			end
			r[i*8 +: 8] = c;
		end
		return r;
	endfunction

	function automatic logic same_name(input logic [NAME_W-1:0] a,
			input logic [NAME_W-1:0] b, input logic en);
		logic eq;
		eq = 1'b1;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (fold_byte(a[i*8 +: 8], en) != fold_byte(b[i*8 +: 8], en)) begin
				eq = 1'b0;
			end
		end
		return eq;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/name_vote_tally_table.sv =====
// Top level of the name vote tally table: a rotating row of entry cells and its sequencer.
// A vote gives exactly one result, loaded from the emit state after its walk of the row.
// One transaction at a time: a vote makes DEPTH shifts, loads its result and goes idle
// before the next accept; a dump also walks the row, and result stalls can hold either.
// Reset clears the sequencer and the used-entry count and sets the fold flag to 1.
// Cell contents are left as they are; no clearing pass runs after reset.
`default_nettype none

module name_vote_tally_table
	import nvt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output      logic         item_stall,
	input  wire logic         kind,
	input  wire logic [63:0]  name_bytes_0_7,
	input  wire logic [63:0]  name_bytes_8_15,
	input  wire logic [23:0]  name_bytes_16_18,
	input  wire logic         cfg_valid,
	output      logic         cfg_ready,
	input  wire logic         fold_case,
	output      logic         result_valid,
	input  wire logic         result_stall,
	output      logic [4:0]   entry_index,
	output      logic [63:0]  out_name_0_7,
	output      logic [63:0]  out_name_8_15,
	output      logic [23:0]  out_name_16_18,
	output      logic [15:0]  vote_count,
	output      logic         is_new_entry,
	output      logic         dropped_full,
	output      logic         entry_valid,
	output      logic         last
);

	// The table lives in a ring of DEPTH cells. Cell 0 is the head: on each shift
	// every cell takes its upper neighbor's entry and the last cell takes the head's
	// entry, possibly updated. After DEPTH shifts the ring is back in its original
	// order, so the head shows entry k on shift step k of a transaction.
	entry_t            cell_entry [DEPTH];
	chain_ctl_t        ctl;
	logic [NAME_W-1:0] key;
	logic [NAME_W-1:0] item_name;
	logic [NAME_W-1:0] out_name;

	assign item_name = {name_bytes_16_18, name_bytes_8_15, name_bytes_0_7};

	// The configuration register is always writable; software must write it only
	// while no transaction is in flight, and the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		// Only the cell fed from the head applies an increment or a new entry;
		// the rest simply pass entries along.
		cell_op_t cell_op;
		entry_t   nbr;
		assign cell_op = (g == DEPTH - 1) ? ctl.op : OP_PASS;
		assign nbr     = cell_entry[(g + 1) % DEPTH];

		nvt_cell u_cell (
			.clk      (clk),
			.shift    (ctl.shift),
			.op       (cell_op),
			.nbr      (nbr),
			.new_name (key),
			.entry    (cell_entry[g])
		);
	end

	// The sequencer compares the canonical key with the head entry on each step,
	// folding case if enabled, and decides the update. Its result register lets the
	// ring move on while a result waits, but a dump holds until that result is taken.
	nvt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.item_name    (item_name),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.fold_case    (fold_case),
		.head         (cell_entry[0]),
		.ctl          (ctl),
		.key          (key),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.entry_index  (entry_index),
		.out_name     (out_name),
		.vote_count   (vote_count),
		.is_new_entry (is_new_entry),
		.dropped_full (dropped_full),
		.entry_valid  (entry_valid),
		.last         (last)
	);

	assign out_name_0_7   = out_name[63:0];
	assign out_name_8_15  = out_name[127:64];
	assign out_name_16_18 = out_name[151:128];

endmodule

`default_nettype wire

// ===== rtl/core/nvt_cell.sv =====
// One table cell: holds an entry and takes its neighbor's entry on every shift.
`default_nettype none

module nvt_cell
	import nvt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              shift,
	input  wire cell_op_t          op,
	input  wire entry_t            nbr,
	input  wire logic [NAME_W-1:0] new_name,
	output      entry_t            entry
);

	entry_t entry_q;

	// The update op only matters in the cell fed from the head of the row.
	always_ff @(posedge clk) begin
		if (shift) begin
			unique case (op)
				OP_PASS: entry_q <= nbr;
				OP_INC: begin
					entry_q.name  <= nbr.name;
					entry_q.count <= sat_inc(nbr.count);
				end
				OP_NEW: begin
					entry_q.name  <= new_name;
					entry_q.count <= COUNT_WIDTH'(1);
				end
				default: entry_q <= nbr;
			endcase
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/nvt_ctrl.sv =====
// Sequencer: takes transactions, walks the rotating cell row, and forms results.
`default_nettype none

module nvt_ctrl
	import nvt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output      logic              item_stall,
	input  wire logic              kind,
	input  wire logic [NAME_W-1:0] item_name,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic              fold_case,
	input  wire entry_t            head,
	output      chain_ctl_t        ctl,
	output      logic [NAME_W-1:0] key,
	output      logic              result_valid,
	input  wire logic              result_stall,
	output      logic [4:0]        entry_index,
	output      logic [NAME_W-1:0] out_name,
	output      logic [15:0]       vote_count,
	output      logic              is_new_entry,
	output      logic              dropped_full,
	output      logic              entry_valid,
	output      logic              last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_VOTE,
		ST_EMIT,
		ST_DUMP
	} state_t;

	state_t                 state_q;
	logic                   fold_q;
	logic [IDX_W-1:0]       step_q;
	logic [USED_W-1:0]      used_q;
	logic [NAME_W-1:0]      key_q;
	logic                   found_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [NAME_W-1:0]      hit_name_q;
	logic [COUNT_WIDTH-1:0] hit_count_q;
	logic                   hit_new_q;

	logic                   result_valid_q;
	logic [4:0]             entry_index_q;
	logic [NAME_W-1:0]      out_name_q;
	logic [15:0]            vote_count_q;
	logic                   is_new_entry_q;
	logic                   dropped_full_q;
	logic                   entry_valid_q;
	logic                   last_q;

	logic [USED_W-1:0] step_ext;
	logic [USED_W-1:0] n_eff;
	logic              in_use;
	logic              last_step;
	logic              slot_free;
	logic              emit_now;
	logic              load_result;
	chain_ctl_t        ctl_c;

	always_comb begin
		step_ext  = USED_W'(step_q);
		n_eff     = (used_q > USED_W'(EMIT_LIMIT)) ? USED_W'(EMIT_LIMIT) : used_q;
		in_use    = step_ext < used_q;
		last_step = step_q == IDX_W'(DEPTH - 1);
		slot_free = !result_valid_q || !result_stall;
		emit_now  = (step_ext < n_eff) || (step_q == '0 && used_q == '0);
		ctl_c.shift = 1'b0;
		ctl_c.op    = OP_PASS;
		unique case (state_q)
			ST_VOTE: begin
				ctl_c.shift = 1'b1;
				if (!found_q && in_use && same_name(key_q, head.name, fold_q)) begin
					ctl_c.op = OP_INC;
				end else if (!found_q && step_ext == used_q) begin
					ctl_c.op = OP_NEW;
				end
			end
			ST_DUMP: ctl_c.shift = !emit_now || slot_free;
			default: ctl_c.shift = 1'b0;
		endcase
		// A new result enters the output register on this edge.
		load_result = (state_q == ST_EMIT && slot_free)
			|| (state_q == ST_DUMP && ctl_c.shift && emit_now);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fold_q         <= 1'b1;
			step_q         <= '0;
			used_q         <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fold_q <= fold_case;
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						key_q   <= canon(item_name);
						step_q  <= '0;
						found_q <= 1'b0;
						state_q <= kind ? ST_DUMP : ST_VOTE;
					end
				end
				ST_VOTE: begin
					step_q <= last_step ? '0 : step_q + 1'b1;
					if (ctl_c.op == OP_INC) begin
						found_q     <= 1'b1;
						hit_idx_q   <= step_q;
						hit_name_q  <= head.name;
						hit_count_q <= sat_inc(head.count);
						hit_new_q   <= 1'b0;
					end else if (ctl_c.op == OP_NEW) begin
						found_q     <= 1'b1;
						hit_idx_q   <= step_q;
						hit_name_q  <= key_q;
						hit_count_q <= COUNT_WIDTH'(1);
						hit_new_q   <= 1'b1;
						used_q      <= used_q + 1'b1;
					end
					if (last_step) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						entry_valid_q  <= 1'b1;
						last_q         <= 1'b1;
						if (found_q) begin
							entry_index_q  <= 5'(hit_idx_q);
							out_name_q     <= hit_name_q;
							vote_count_q   <= 16'(hit_count_q);
							is_new_entry_q <= hit_new_q;
							dropped_full_q <= 1'b0;
						end else begin
							entry_index_q  <= '0;
							out_name_q     <= '0;
							vote_count_q   <= '0;
							is_new_entry_q <= 1'b0;
							dropped_full_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (ctl_c.shift) begin
						step_q <= last_step ? '0 : step_q + 1'b1;
						if (emit_now) begin
							is_new_entry_q <= 1'b0;
							dropped_full_q <= 1'b0;
							entry_index_q  <= 5'(step_q);
							if (used_q == '0) begin
								out_name_q    <= '0;
								vote_count_q  <= '0;
								entry_valid_q <= 1'b0;
								last_q        <= 1'b1;
							end else begin
								out_name_q    <= head.name;
								vote_count_q  <= 16'(head.count);
								entry_valid_q <= 1'b1;
								last_q        <= step_ext == n_eff - 1'b1;
							end
						end
						if (last_step) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign ctl          = ctl_c;
	assign key          = key_q;
	assign result_valid = result_valid_q;
	assign entry_index  = entry_index_q;
	assign out_name     = out_name_q;
	assign vote_count   = vote_count_q;
	assign is_new_entry = is_new_entry_q;
	assign dropped_full = dropped_full_q;
	assign entry_valid  = entry_valid_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/nvt_checker.sv =====
// Port-level checks for the name vote tally table, bound to the top level.
`default_nettype none

module nvt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [4:0]  entry_index,
	input wire logic [15:0] vote_count,
	input wire logic        is_new_entry,
	input wire logic        dropped_full,
	input wire logic        entry_valid,
	input wire logic        last
);

	// A transaction once taken stalls the input in the cycle after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken again right after a transaction");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(vote_count)
			&& $stable(entry_index) && $stable(last))
		else $error("stalled result changed");

	// Only dumps give more than one result, and dump results carry no vote flags.
	a_multi_is_dump: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> entry_valid && !is_new_entry && !dropped_full)
		else $error("non-final result is not a dump entry");

	a_dropped_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dropped_full |-> last && entry_valid && !is_new_entry
			&& vote_count == 16'h0000)
		else $error("malformed dropped vote result");

	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !entry_valid |-> last && entry_index == 5'd0
			&& vote_count == 16'h0000 && !dropped_full)
		else $error("malformed empty dump result");

endmodule

bind name_vote_tally_table nvt_checker u_nvt_checker (.*);

`default_nettype wire

// ===== tb/sv/nvt_tally_monitor.sv =====
// Shared stimulus codes and the monitor that predicts and checks the name vote tally table.

package nvt_tb_pkg;

	localparam logic KIND_VOTE = 1'b0;
	localparam logic KIND_DUMP = 1'b1;

	// Cycles to let pass after the last result before the block counts as idle.
	localparam int SETTLE_CYCLES = 48;

endpackage

module nvt_tally_monitor
	import nvt_pkg::*, nvt_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic        kind,
	input  logic [63:0] name_bytes_0_7,
	input  logic [63:0] name_bytes_8_15,
	input  logic [23:0] name_bytes_16_18,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        fold_case,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [4:0]  entry_index,
	input  logic [63:0] out_name_0_7,
	input  logic [63:0] out_name_8_15,
	input  logic [23:0] out_name_16_18,
	input  logic [15:0] vote_count,
	input  logic        is_new_entry,
	input  logic        dropped_full,
	input  logic        entry_valid,
	input  logic        last,
	output int          errors,
	output int          outstanding
);

	typedef struct packed {
		logic [4:0]        slot;
		logic [NAME_W-1:0] name;
		logic [15:0]       votes;
		logic              fresh;
		logic              dropped;
		logic              present;
		logic              tail;
	} tally_result_t;

	logic [NAME_W-1:0]      tally_name  [DEPTH];
	logic [COUNT_WIDTH-1:0] tally_votes [DEPTH];
	int                     tally_used = 0;
	logic                   fold_on    = 1'b1;
	int                     fault_n    = 0;
	tally_result_t          awaited [$];

	// Everything after the first zero byte counts as zero.
	function automatic logic [NAME_W-1:0] strip_tail(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] r;
		logic              done;
		r    = raw;
		done = 1'b0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (done) begin
				r[b*8 +: 8] = 8'h00;
			end else if (raw[b*8 +: 8] == 8'h00) begin
				done = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] case_key(input logic [7:0] c, input logic fold);
		if (fold && c >= "A" && c <= "Z") begin
			return c | 8'h20;
		end
		return c;
	endfunction

	function automatic logic names_match(input logic [NAME_W-1:0] a,
			input logic [NAME_W-1:0] b, input logic fold);
		logic eq;
		eq = 1'b1;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (case_key(a[k*8 +: 8], fold) != case_key(b[k*8 +: 8], fold)) begin
				eq = 1'b0;
			end
		end
		return eq;
	endfunction

	// Updates the tally for one transaction and queues the results it must give.
	task automatic tally_item(input logic k, input logic [NAME_W-1:0] raw);
		tally_result_t     r;
		logic [NAME_W-1:0] nm;
		int                hit;
		int                n;
		r = '0;
		if (k == KIND_DUMP) begin
			n = (tally_used < MAX_EMIT) ? tally_used : MAX_EMIT;
			if (n == 0) begin
				r.tail = 1'b1;
				awaited.push_back(r);
			end
			for (int e = 0; e < n; e++) begin
				r.slot    = e[4:0];
				r.name    = tally_name[e];
				r.votes   = tally_votes[e][15:0];
				r.present = 1'b1;
				r.tail    = (e == n - 1);
				awaited.push_back(r);
			end
		end else begin
			nm  = strip_tail(raw);
			hit = -1;
			for (int e = 0; e < tally_used; e++) begin
				if (hit < 0 && names_match(nm, tally_name[e], fold_on)) begin
					hit = e;
				end
			end
			r.present = 1'b1;
			r.tail    = 1'b1;
			if (hit >= 0) begin
				if (!(&tally_votes[hit])) begin
					tally_votes[hit] = tally_votes[hit] + 1'b1;
				end
				r.slot  = hit[4:0];
				r.name  = tally_name[hit];
				r.votes = tally_votes[hit][15:0];
			end else if (tally_used >= DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				tally_name[tally_used]  = nm;
				tally_votes[tally_used] = COUNT_WIDTH'(1);
				r.slot  = tally_used[4:0];
				r.name  = nm;
				r.votes = 16'd1;
				r.fresh = 1'b1;
				tally_used++;
			end
			awaited.push_back(r);
		end
	endtask

	task automatic match_field(input string label, input logic [NAME_W-1:0] want,
			input logic [NAME_W-1:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0h actual %0h", $time, label, want, got);
			fault_n++;
		end
	endtask

	task automatic check_result();
		tally_result_t want;
		if (awaited.size() == 0) begin
			$display("%0t unexpected result: expected none actual entry_index %0d",
				$time, entry_index);
			fault_n++;
		end else begin
			want = awaited.pop_front();
			match_field("entry_index", NAME_W'(want.slot), NAME_W'(entry_index));
			match_field("out_name_0_7", NAME_W'(want.name[63:0]), NAME_W'(out_name_0_7));
			match_field("out_name_8_15", NAME_W'(want.name[127:64]),
				NAME_W'(out_name_8_15));
			match_field("out_name_16_18", NAME_W'(want.name[151:128]),
				NAME_W'(out_name_16_18));
			match_field("vote_count", NAME_W'(want.votes), NAME_W'(vote_count));
			match_field("is_new_entry", NAME_W'(want.fresh), NAME_W'(is_new_entry));
			match_field("dropped_full", NAME_W'(want.dropped), NAME_W'(dropped_full));
			match_field("entry_valid", NAME_W'(want.present), NAME_W'(entry_valid));
			match_field("last", NAME_W'(want.tail), NAME_W'(last));
		end
	endtask

	// Results are compared before a new transaction is queued at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_used = 0;
			fold_on    = 1'b1;
			awaited.delete();
		end else begin
			if (result_valid && !result_stall) begin
				check_result();
			end
			if (cfg_valid && cfg_ready) begin
				fold_on = fold_case;
			end
			if (item_valid && !item_stall) begin
				tally_item(kind, {name_bytes_16_18, name_bytes_8_15, name_bytes_0_7});
			end
		end
		errors      <= fault_n;
		outstanding <= awaited.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the name vote tally table testbench: clock, reset, stimulus and verdict.

module tb;

	import nvt_pkg::*;
	import nvt_tb_pkg::*;

	// Size of the pool of recurring names. It is larger than the table, so the
	// table fills up and votes for names that come late are dropped.
	localparam int POOL_N = 40;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid;
	logic        kind;
	logic [63:0] name_bytes_0_7;
	logic [63:0] name_bytes_8_15;
	logic [23:0] name_bytes_16_18;
	logic        cfg_valid;
	logic        fold_case;
	logic        result_stall;
	wire         item_stall;
	wire         cfg_ready;
	wire         result_valid;
	wire [4:0]   entry_index;
	wire [63:0]  out_name_0_7;
	wire [63:0]  out_name_8_15;
	wire [23:0]  out_name_16_18;
	wire [15:0]  vote_count;
	wire         is_new_entry;
	wire         dropped_full;
	wire         entry_valid;
	wire         last;
	int          errors;
	int          outstanding;

	// Set for the last part of the run: no gaps from the sender, no stalls on results.
	bit calm = 1'b0;

	logic [NAME_W-1:0] pool [POOL_N];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	name_vote_tally_table dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.name_bytes_0_7   (name_bytes_0_7),
		.name_bytes_8_15  (name_bytes_8_15),
		.name_bytes_16_18 (name_bytes_16_18),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.fold_case        (fold_case),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.entry_index      (entry_index),
		.out_name_0_7     (out_name_0_7),
		.out_name_8_15    (out_name_8_15),
		.out_name_16_18   (out_name_16_18),
		.vote_count       (vote_count),
		.is_new_entry     (is_new_entry),
		.dropped_full     (dropped_full),
		.entry_valid      (entry_valid),
		.last             (last)
	);

	// The monitor watches all three channels, keeps its own tally and compares
	// every accepted result with the oldest one it expects.
	nvt_tally_monitor tally_mon (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.kind             (kind),
		.name_bytes_0_7   (name_bytes_0_7),
		.name_bytes_8_15  (name_bytes_8_15),
		.name_bytes_16_18 (name_bytes_16_18),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.fold_case        (fold_case),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.entry_index      (entry_index),
		.out_name_0_7     (out_name_0_7),
		.out_name_8_15    (out_name_8_15),
		.out_name_16_18   (out_name_16_18),
		.vote_count       (vote_count),
		.is_new_entry     (is_new_entry),
		.dropped_full     (dropped_full),
		.entry_valid      (entry_valid),
		.last             (last),
		.errors           (errors),
		.outstanding      (outstanding)
	);

	// Packs a text into name bytes, first character in the low byte.
	function automatic logic [NAME_W-1:0] text_name(input string s);
		logic [NAME_W-1:0] r;
		r = '0;
		for (int b = 0; b < s.len() && b < NAME_BYTES; b++) begin
			r[b*8 +: 8] = s[b];
		end
		return r;
	endfunction

	function automatic logic [NAME_W-1:0] random_bits();
		logic [159:0] r;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		return r[NAME_W-1:0];
	endfunction

	// A name of mixed-case letters with the given number of characters.
	function automatic logic [NAME_W-1:0] made_up_name(input int len);
		logic [NAME_W-1:0] r;
		r = '0;
		for (int b = 0; b < len; b++) begin
			if ($urandom_range(0, 1) == 0) begin
				r[b*8 +: 8] = 8'($urandom_range(65, 90));
			end else begin
				r[b*8 +: 8] = 8'($urandom_range(97, 122));
			end
		end
		return r;
	endfunction

	// The same name with some letters in the other case and, now and then,
	// nonzero junk behind the terminating zero byte. With case folding on,
	// both still match the stored entry.
	function automatic logic [NAME_W-1:0] spelled_like(input logic [NAME_W-1:0] base);
		logic [NAME_W-1:0] r;
		logic [7:0]        c;
		logic              ended;
		r     = base;
		ended = 1'b0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			c = base[b*8 +: 8];
			if (ended) begin
				if ($urandom_range(0, 3) == 0) begin
					r[b*8 +: 8] = 8'($urandom_range(1, 255));
				end
			end else if (c == 8'h00) begin
				ended = 1'b1;
			end else if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
					&& $urandom_range(0, 2) == 0) begin
				r[b*8 +: 8] = c ^ 8'h20;
			end
		end
		return r;
	endfunction

	// Offers one transaction and returns at the edge where it is taken. The
	// valid is left high, so a following transaction goes out back to back
	// unless a random gap lowers it first.
	task automatic offer_item(input logic k, input logic [NAME_W-1:0] nm);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid       <= 1'b1;
		kind             <= k;
		name_bytes_0_7   <= nm[63:0];
		name_bytes_8_15  <= nm[127:64];
		name_bytes_16_18 <= nm[151:128];
		do @(posedge clk); while (item_stall);
	endtask

	// Mostly votes for recurring names so that matches, count updates and a
	// full table are reached; the rest are short names, which collide often,
	// random noise, and dumps whose name bytes carry junk.
	task automatic offer_random();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			offer_item(KIND_DUMP, random_bits());
		end else if (pick < 75) begin
			offer_item(KIND_VOTE, spelled_like(pool[$urandom_range(0, POOL_N - 1)]));
		end else if (pick < 88) begin
			offer_item(KIND_VOTE, spelled_like(made_up_name($urandom_range(1, 3))));
		end else begin
			offer_item(KIND_VOTE, random_bits());
		end
	endtask

	// Holds off the sender until every expected result has come and the row
	// has finished its walk. Every register write but the first follows this.
	task automatic drain_tally();
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fold(input logic v);
		cfg_valid <= 1'b1;
		fold_case <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Result side: quiet stretches broken by stall bursts, none once the run is calm.
	initial begin
		result_stall <= 1'b0;
		forever begin
			repeat ($urandom_range(1, 15)) @(posedge clk);
			if (!calm) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [NAME_W-1:0] bob_junk;
		item_valid       <= 1'b0;
		kind             <= KIND_VOTE;
		name_bytes_0_7   <= '0;
		name_bytes_8_15  <= '0;
		name_bytes_16_18 <= '0;
		cfg_valid        <= 1'b0;
		fold_case        <= 1'b1;

		// The first pool name uses all 19 bytes, so no terminating zero at all.
		pool[0] = made_up_name(NAME_BYTES);
		for (int p = 1; p < POOL_N; p++) begin
			pool[p] = made_up_name($urandom_range(1, NAME_BYTES));
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_fold(1'b1);

		// Directed part, case folding on. A dump of the empty table gives a
		// single result marked as not valid.
		offer_item(KIND_DUMP, '0);
		// The all-zero name is an ordinary name.
		offer_item(KIND_VOTE, '0);
		// Case variants of one name land on the same entry, which keeps the
		// first spelling.
		offer_item(KIND_VOTE, text_name("Alice"));
		offer_item(KIND_VOTE, text_name("ALICE"));
		offer_item(KIND_VOTE, text_name("alice"));
		// Bytes behind the terminating zero are ignored for matching and storing.
		bob_junk = text_name("Bob");
		bob_junk[NAME_W-1:32] = (NAME_W - 32)'(random_bits());
		offer_item(KIND_VOTE, bob_junk);
		offer_item(KIND_VOTE, text_name("Bob"));
		// Every input bit set: 0xff is no letter and the name has no terminator.
		offer_item(KIND_VOTE, '1);
		// Characters just outside the letter ranges must not fold into each other.
		offer_item(KIND_VOTE, text_name("@["));
		offer_item(KIND_VOTE, text_name("`{"));
		offer_item(KIND_VOTE, text_name("AZ"));
		offer_item(KIND_VOTE, text_name("az"));
		offer_item(KIND_DUMP, '1);

		// Exact comparison: other spellings now become entries of their own.
		drain_tally();
		write_fold(1'b0);
		offer_item(KIND_VOTE, text_name("ALICE"));
		offer_item(KIND_VOTE, text_name("Alice"));
		offer_item(KIND_VOTE, text_name("aZ"));
		offer_item(KIND_DUMP, '0);

		// Random part in three settings. The sender waits for the block to run
		// dry before each register write.
		drain_tally();
		write_fold(1'b1);
		for (int n = 0; n < 50; n++) begin
			offer_random();
		end
		drain_tally();
		write_fold(1'b0);
		for (int n = 0; n < 45; n++) begin
			offer_random();
		end
		drain_tally();
		write_fold(1'b1);
		for (int n = 0; n < 40; n++) begin
			if (n == 20) begin
				calm = 1'b1;
			end
			offer_random();
		end

		// Wait for every expected result, then a while longer in case the
		// block produces anything extra.
		item_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("PASS name_vote_tally_table");
		end else begin
			$display("FAIL name_vote_tally_table");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run: every dump result stalled
	// for the longest burst and every transaction behind the longest gap.
	initial begin
		#4_000_000;
		$display("FAIL name_vote_tally_table");
		$finish;
	end

endmodule
